// ===== src/imu_complementary_tilt_filter_assert.svh =====
// assertion macros for the complementary tilt filter checker
// expects signals clk and rst_n in the scope of use
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// same-cycle implication
`define ICTF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tilt filter assertion failed");

// next-cycle implication
`define ICTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tilt filter assertion failed");

`endif

// ===== src/imu_ctf_pkg.sv =====
// shared types, codes and constants of the complementary tilt filter
// no dependencies
package imu_ctf_pkg;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_BLEND_MUL,
    ST_BLEND_ADD,
    ST_DIV2,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic prep;
    logic run_step;
    logic blend_mul;
    logic blend_add;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic run_done;
    logic div_done;
  } status_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME    = 2'd1;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd64225;
  localparam logic [19:0] STEP_TIME_RST    = 20'd10000;

  // reciprocals of the constant divisors and rounding offsets
  // gyro: (n >> 1) / 125 as * RCP_GYRO >> 41, exact for 34-bit operands
  // velocity: (n >> 11) / 15625 as * RCP_VEL >> 47, exact for 33-bit operands
  localparam logic [34:0] RCP_GYRO  = 35'd17592186045;
  localparam logic [34:0] RCP_VEL   = 35'd9007199255;
  localparam logic [34:0] RND_GYRO  = 35'd125;
  localparam logic [43:0] RND_VEL   = 44'd16000000;
  localparam logic [4:0]  DIV_STEPS = 5'd2;

  // angles in q16.16 degrees
  localparam logic signed [26:0] ANGLE_90  = 27'sd5898240;
  localparam logic signed [26:0] ANGLE_180 = 27'sd11796480;

  localparam logic [18:0] VEL_MAX = 19'h7FFFF;

  // arctangent of 2^-i in q16.16 degrees
  function automatic logic signed [26:0] atan_q16(input logic [4:0] idx);
    logic signed [26:0] v;
    unique case (idx)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117304;
      5'd6:  v = 27'sd58710;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/imu_ctf_ctrl.sv =====
// sequencing controller of the complementary tilt filter
// depends on imu_ctf_pkg
module imu_ctf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  imu_ctf_pkg::status_t status,
  output imu_ctf_pkg::cmd_t    cmd
);
  import imu_ctf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_PREP;
      ST_PREP:      state_nxt = ST_RUN;
      ST_RUN:       if (status.run_done) state_nxt = ST_BLEND_MUL;
      ST_BLEND_MUL: state_nxt = ST_BLEND_ADD;
      ST_BLEND_ADD: state_nxt = ST_DIV2;
      ST_DIV2:      if (status.div_done) state_nxt = ST_DONE;
      ST_DONE:      if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_PREP:      cmd.prep = 1'b1;
      ST_RUN:       cmd.run_step = 1'b1;
      ST_BLEND_MUL: cmd.blend_mul = 1'b1;
      ST_BLEND_ADD: begin
        cmd.blend_add = 1'b1;
        cmd.div_step  = 1'b1;
      end
      ST_DIV2:      cmd.div_step = 1'b1;
      ST_DONE:      cmd.out_load = !out_valid_r || out_ready;
      default:      cmd = '0;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/imu_ctf_dp.sv =====
// datapath: config registers, constant dividers, atan2 cordic, square root, blend
// depends on imu_ctf_pkg
module imu_ctf_dp #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  imu_ctf_pkg::cmd_t                     cmd,
  output imu_ctf_pkg::status_t                  status,
  input  logic                                  cfg_we,
  input  logic [imu_ctf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imu_ctf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic signed [15:0]                    accel_x,
  input  logic signed [15:0]                    accel_y,
  input  logic signed [15:0]                    accel_z,
  input  logic signed [15:0]                    gyro_x,
  output logic signed [31:0]                    tilt_angle,
  output logic [18:0]                           velocity_step
);
  import imu_ctf_pkg::*;

  localparam int ICW = $clog2(CORDIC_STEPS + 1);
  localparam logic [ICW-1:0] CSTEPS = ICW'(CORDIC_STEPS);
  localparam logic [15:0] KEEP = 16'hFFFF << (16 - SAMPLE_BITS);

  logic [15:0]        blend_weight_r;
  logic [19:0]        step_time_r;
  logic signed [15:0] ax_r, ay_r, az_r, gx_r;
  logic signed [31:0] angle_r;
  logic               p_neg_r;

  logic [33:0] div_n_r;
  logic [68:0] div_acc_r;
  logic [27:0] div_quo;
  logic [4:0]  div_cnt_r;
  logic        div_mode_r;

  logic signed [33:0] cx_r, cy_r;
  logic signed [26:0] cz_r;
  logic [ICW-1:0]     ci_r;

  logic [47:0] sq_v_r, sq_root_r;
  logic [46:0] sq_bit_r;

  logic signed [49:0] prod_a_r;
  logic signed [44:0] prod_b_r;
  logic signed [31:0] tilt_r;
  logic [18:0]        vel_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= BLEND_WEIGHT_RST;
      step_time_r    <= STEP_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_WEIGHT: blend_weight_r <= cfg_wdata[15:0];
        REG_STEP_TIME:    step_time_r    <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // sample capture, low bits cleared
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax_r <= $signed(accel_x & KEEP);
      ay_r <= $signed(accel_y & KEEP);
      az_r <= $signed(accel_z & KEEP);
      gx_r <= $signed(gyro_x & KEEP);
    end
  end

  // gyro increment numerator
  logic signed [36:0] p_full;
  logic [36:0]        p_abs;
  logic [34:0]        d1;
  assign p_full = gx_r * $signed({1'b0, step_time_r});
  assign p_abs  = p_full[36] ? 37'(-p_full) : p_full;
  assign d1     = p_abs[34:0] + RND_GYRO;

  // sum of squares
  logic signed [31:0] sqx, sqy, sqz;
  logic [31:0]        ss;
  assign sqx = ax_r * ax_r;
  assign sqy = ay_r * ay_r;
  assign sqz = az_r * az_r;
  assign ss  = 32'(sqx) + 32'(sqy) + 32'(sqz);

  // velocity numerator
  logic [43:0] d2;
  assign d2 = 44'(sq_root_r[23:0] * step_time_r) + RND_VEL;

  // division by a constant: reciprocal product in two partial products
  logic [34:0] rcp;
  logic [16:0] n_part;
  logic [51:0] pp;
  assign rcp     = div_mode_r ? RCP_VEL : RCP_GYRO;
  assign n_part  = (div_cnt_r == DIV_STEPS) ? div_n_r[16:0] : div_n_r[33:17];
  assign pp      = rcp * n_part;
  assign div_quo = div_mode_r ? 28'(div_acc_r[68:47]) : div_acc_r[68:41];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.prep) begin
      div_mode_r <= 1'b0;
      div_n_r    <= d1[34:1];
      div_cnt_r  <= DIV_STEPS;
    end else if (cmd.blend_mul) begin
      div_mode_r <= 1'b1;
      div_n_r    <= {1'b0, d2[43:11]};
      div_cnt_r  <= DIV_STEPS;
    end else if ((cmd.run_step || cmd.div_step) && div_cnt_r != '0) begin
      if (div_cnt_r == DIV_STEPS) begin
        div_acc_r <= 69'(pp);
      end else begin
        div_acc_r <= div_acc_r + {pp, 17'd0};
      end
      div_cnt_r <= div_cnt_r - 5'd1;
    end
  end

  // cordic vectoring for atan2(ay, az)
  logic signed [33:0] x0, y0, xs, ys;
  assign x0 = 34'(az_r) <<< 14;
  assign y0 = 34'(ay_r) <<< 14;
  assign xs = cx_r >>> ci_r;
  assign ys = cy_r >>> ci_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r <= CSTEPS;
    end else if (cmd.prep) begin
      if (ay_r == 16'sd0) begin
        // on the x axis: zero or half turn
        cz_r <= (az_r >= 16'sd0) ? 27'sd0 : ANGLE_180;
        ci_r <= CSTEPS;
      end else if (az_r < 16'sd0) begin
        ci_r <= '0;
        if (ay_r >= 16'sd0) begin
          cx_r <= y0;
          cy_r <= -x0;
          cz_r <= ANGLE_90;
        end else begin
          cx_r <= -y0;
          cy_r <= x0;
          cz_r <= -ANGLE_90;
        end
      end else begin
        ci_r <= '0;
        cx_r <= x0;
        cy_r <= y0;
        cz_r <= 27'sd0;
      end
    end else if (cmd.run_step && ci_r != CSTEPS) begin
      if (cy_r > 34'sd0) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atan_q16(5'(ci_r));
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atan_q16(5'(ci_r));
      end
      ci_r <= ci_r + 1'b1;
    end
  end

  // bit-pair integer square root of ss << 16
  logic [48:0] sq_trial;
  assign sq_trial = {1'b0, sq_root_r} + {2'b0, sq_bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_bit_r <= '0;
    end else if (cmd.prep) begin
      sq_v_r    <= {ss, 16'd0};
      sq_root_r <= '0;
      sq_bit_r  <= {1'b1, 46'd0};
    end else if (cmd.run_step && sq_bit_r != '0) begin
      if ({1'b0, sq_v_r} >= sq_trial) begin
        sq_v_r    <= 48'({1'b0, sq_v_r} - sq_trial);
        sq_root_r <= (sq_root_r >> 1) + {1'b0, sq_bit_r};
      end else begin
        sq_root_r <= sq_root_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  assign status.run_done = (div_cnt_r == '0) && (ci_r == CSTEPS) && (sq_bit_r == '0);
  assign status.div_done = (div_cnt_r == '0);

  // blend products
  logic signed [28:0] inc;
  logic signed [32:0] prop;
  logic [16:0]        beta;
  assign inc  = p_neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign prop = 33'(angle_r) + 33'(inc);
  assign beta = 17'd65536 - {1'b0, blend_weight_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      p_neg_r <= p_full[36];
    end
    if (cmd.blend_mul) begin
      prod_a_r <= $signed({1'b0, blend_weight_r}) * prop;
      prod_b_r <= $signed({1'b0, beta}) * cz_r;
    end
  end

  // round, shift and saturate
  logic signed [50:0] bsum;
  logic signed [34:0] bsh;
  logic signed [31:0] bsat;
  assign bsum = 51'(prod_a_r) + 51'(prod_b_r) + 51'sd32768;
  assign bsh  = bsum[50:16];
  always_comb begin
    if (bsh > 35'sd2147483647) begin
      bsat = 32'sh7FFFFFFF;
    end else if (bsh < -35'sd2147483648) begin
      bsat = 32'sh80000000;
    end else begin
      bsat = bsh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else if (cmd.blend_add) begin
      angle_r <= bsat;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tilt_r <= angle_r;
      vel_r  <= (div_quo[27:19] != '0) ? VEL_MAX : div_quo[18:0];
    end
  end

  assign tilt_angle    = tilt_r;
  assign velocity_step = vel_r;

endmodule

// ===== src/imu_complementary_tilt_filter.sv =====
// channel    | handshake              | payload
// in         | in_valid / in_ready    | in_accel_x, in_accel_y, in_accel_z, in_gyro_x
// out        | out_valid / out_ready  | out_tilt_angle, out_velocity_step
// cfg        | cfg_valid / cfg_ready  | cfg_index, cfg_wdata
// one item in flight: no new input is taken until the result is loaded. The run
// phase is set by the 24-step square root, or by cordic when CORDIC_STEPS exceeds
// 24, with the others and the two-step gyro reciprocal beside it, then two velocity steps.
// a waiting result does not block the next input transfer; a stalled result holds
// the block in its final step until taken. cfg is always ready.
// synchronous active-low reset clears angle, registers and control.
// top level: ties controller and datapath, depends on imu_ctf_pkg
module imu_complementary_tilt_filter #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 in_accel_x,
  input  logic signed [15:0]                 in_accel_y,
  input  logic signed [15:0]                 in_accel_z,
  input  logic signed [15:0]                 in_gyro_x,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 out_tilt_angle,
  output logic [18:0]                        out_velocity_step,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [imu_ctf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imu_ctf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import imu_ctf_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  imu_ctf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  imu_ctf_dp #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .accel_x       (in_accel_x),
    .accel_y       (in_accel_y),
    .accel_z       (in_accel_z),
    .gyro_x        (in_gyro_x),
    .tilt_angle    (out_tilt_angle),
    .velocity_step (out_velocity_step)
  );

endmodule

// ===== src/imu_ctf_chk.sv =====
// port-level checker for the complementary tilt filter, bound to the top level
// depends on imu_complementary_tilt_filter_assert.svh
`include "imu_complementary_tilt_filter_assert.svh"

module imu_ctf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_tilt_angle
);

  // stalled result holds
  `ICTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tilt_angle))

  // busy right after an input transfer
  `ICTF_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

  // no result the cycle after an input transfer
  `ICTF_ASSERT_NEXT(a_no_instant_out, in_valid && in_ready, !$rose(out_valid))

  // a new result only comes out of a busy block
  `ICTF_ASSERT_IMPL(a_out_from_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind imu_complementary_tilt_filter imu_ctf_chk u_chk (.*);

// ===== test/imu_complementary_tilt_filter_checker.sv =====
// checker for the complementary tilt filter: watches the sample, result and register
// channels, predicts each result and compares it; depends on imu_ctf_pkg
`timescale 1ns / 100ps

module imu_complementary_tilt_filter_checker #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [15:0]                 in_accel_x,
  input  logic signed [15:0]                 in_accel_y,
  input  logic signed [15:0]                 in_accel_z,
  input  logic signed [15:0]                 in_gyro_x,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [31:0]                 out_tilt_angle,
  input  logic [18:0]                        out_velocity_step,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [imu_ctf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imu_ctf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 samples_seen,
  output int                                 results_seen
);
  import imu_ctf_pkg::*;

  typedef struct {
    logic signed [31:0] tilt_angle;
    logic [18:0]        velocity_step;
  } tilt_result_t;

  // arctangent of 2^-i, q16.16 degrees
  localparam longint ATAN_DEG[32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58710, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  tilt_result_t        expected_results[$];
  logic [15:0]         alpha;
  logic [19:0]         dt_us;
  logic signed [31:0]  angle_est;

  // keep only the top sample bits, scale unchanged
  function automatic longint trim_sample(logic [15:0] raw);
    logic [15:0] v;
    v = raw & (16'hFFFF << (16 - SAMPLE_BITS));
    return longint'(signed'(v));
  endfunction

  // cordic vectoring atan2 in q16.16 degrees
  function automatic longint accel_tilt(longint y, longint x);
    longint z, t, xs, ys;
    int i;
    z = 0;
    if (y == 0) return (x >= 0) ? 0 : 180 * 65536;
    x = x * 16384;
    y = y * 16384;
    // pre-rotate into the right half plane
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_DEG[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_DEG[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // one filter step: updates the held angle, returns the expected result
  function automatic tilt_result_t filter_step(logic [15:0] rx, logic [15:0] ry,
                                               logic [15:0] rz, logic [15:0] rg);
    longint ax, ay, az, gx, p, m, inc, prop, acc, mix;
    longint unsigned ss, mag, vel;
    tilt_result_t r;
    ax = trim_sample(rx);
    ay = trim_sample(ry);
    az = trim_sample(rz);
    gx = trim_sample(rg);
    // gyro increment, rounded half away from zero
    p = gx * longint'(dt_us);
    m = (p < 0) ? -p : p;
    inc = (m + 125) / 250;
    if (p < 0) inc = -inc;
    prop = longint'(angle_est) + inc;
    acc = accel_tilt(ay, az);
    mix = longint'(alpha) * prop + (65536 - longint'(alpha)) * acc;
    mix = (mix + 32768) >>> 16;
    if (mix > 64'sd2147483647) mix = 64'sd2147483647;
    if (mix < -64'sd2147483648) mix = -64'sd2147483648;
    angle_est = mix[31:0];
    // magnitude times interval
    ss = longint'(ax * ax + ay * ay + az * az);
    mag = int_sqrt(ss << 16);
    vel = (mag * longint'(dt_us) + 16000000) / 32000000;
    if (vel > 524287) vel = 524287;
    r.tilt_angle    = angle_est;
    r.velocity_step = vel[18:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    tilt_result_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      alpha        <= BLEND_WEIGHT_RST;
      dt_us        <= STEP_TIME_RST;
      angle_est    = '0;
      fail_count   <= 0;
      samples_seen <= 0;
      results_seen <= 0;
      expected_results.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BLEND_WEIGHT) alpha <= cfg_wdata[15:0];
        else if (cfg_index == REG_STEP_TIME) dt_us <= cfg_wdata;
      end
      // sample transfer
      if (in_valid && in_ready) begin
        expected_results.push_back(filter_step(in_accel_x, in_accel_y, in_accel_z,
                                               in_gyro_x));
        samples_seen <= samples_seen + 1;
      end
      // result transfer
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result: tilt_angle %0d velocity_step %0d",
                 out_tilt_angle, out_velocity_step);
          errs++;
        end else begin
          e = expected_results.pop_front();
          if (out_tilt_angle !== e.tilt_angle) begin
            $error("tilt_angle: expected %0d, got %0d", e.tilt_angle, out_tilt_angle);
            errs++;
          end
          if (out_velocity_step !== e.velocity_step) begin
            $error("velocity_step: expected %0d, got %0d", e.velocity_step,
                   out_velocity_step);
            errs++;
          end
        end
      end
      // one update of the failure count per cycle
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== test/imu_complementary_tilt_filter_tb.sv =====
// testbench top for the complementary tilt filter: drives samples and register
// writes, stalls the result side; depends on imu_ctf_pkg and the checker module
`timescale 1ns / 100ps

module imu_complementary_tilt_filter_tb;
  import imu_ctf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [15:0]    in_accel_x = '0;
  logic signed [15:0]    in_accel_y = '0;
  logic signed [15:0]    in_accel_z = '0;
  logic signed [15:0]    in_gyro_x = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [31:0]    out_tilt_angle;
  logic [18:0]           out_velocity_step;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count, pending, samples_seen, results_seen;
  int reg_writes = 0;
  bit gaps_on = 1'b1;
  bit long_hold = 1'b0;

  imu_complementary_tilt_filter DUT (.*);

  imu_complementary_tilt_filter_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      out_ready <= !gaps_on || ($urandom_range(99) >= 22);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL imu_complementary_tilt_filter");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] gx);
    if (gaps_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_gyro_x  <= gx;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for every result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(0, 400)) - 200);
      5, 6: return 16'($signed($urandom_range(0, 16384)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_samples(int n);
    repeat (n) send_sample(pick_axis(), pick_axis(), pick_axis(), pick_axis());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed samples with reset register values
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // all axes zero
    send_sample(16'h0100, 16'h0000, 16'h2000, 16'h0000);  // y zero, z positive
    send_sample(16'h0100, 16'h0000, 16'hE000, 16'h0000);  // y zero, z negative
    send_sample(16'h0000, 16'h2000, 16'hE000, 16'h0400);  // z negative, y positive
    send_sample(16'h0000, 16'hE000, 16'hE000, 16'hFC00);  // z negative, y negative
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7FFF, 16'h0000, 16'h0001);
    send_sample(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
    send_sample(16'h0000, 16'h0001, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0001, 16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h2000, 16'h7FFF);
    send_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    drain();

    // accel angle only, shortest nonzero interval
    write_reg(REG_BLEND_WEIGHT, 20'd0);
    write_reg(REG_STEP_TIME, 20'd1);
    random_samples(60);
    drain();

    // almost gyro only, widest interval: drive the angle into both bounds
    write_reg(REG_BLEND_WEIGHT, 20'hFFFFF);
    write_reg(REG_STEP_TIME, 20'hFFFFF);
    repeat (35) send_sample(pick_axis(), pick_axis(), pick_axis(), 16'h7FFF);
    repeat (35) send_sample(pick_axis(), pick_axis(), pick_axis(), 16'h8000);
    drain();

    // zero interval; writes to unused indexes must change nothing
    write_reg(REG_STEP_TIME, 20'd0);
    write_reg(REG_BLEND_WEIGHT, 20'($urandom));
    write_reg(REG_SPARE_A, 20'd12345);
    write_reg(REG_SPARE_B, 20'hFFFFF);
    random_samples(60);
    drain();

    // random registers; long result hold-off, then a stretch with no gaps
    write_reg(REG_BLEND_WEIGHT, 20'($urandom));
    write_reg(REG_STEP_TIME, 20'($urandom_range(1, 1000000)));
    long_hold = 1'b1;
    random_samples(40);
    drain();
    gaps_on = 1'b0;
    random_samples(80);
    drain();
    gaps_on = 1'b1;

    // near-realistic interval and weight
    write_reg(REG_BLEND_WEIGHT, 20'd64225);
    write_reg(REG_STEP_TIME, 20'd1000000);
    random_samples(80);
    drain();
    write_reg(REG_BLEND_WEIGHT, 20'h08000);
    write_reg(REG_STEP_TIME, 20'($urandom_range(1, 20000)));
    random_samples(80);
    drain();

    $display("run covered %0d samples and %0d results across %0d register writes",
             samples_seen, results_seen, reg_writes);
    $display("included angle saturation, zero interval and a long result stall");
    if (fail_count == 0 && pending == 0)
      $display("PASS imu_complementary_tilt_filter");
    else
      $display("FAIL imu_complementary_tilt_filter");
    $finish;
  end

endmodule
